@@ sv/pdc_pkg.sv @@
// shared types, constants and a helper function of the porous drag cell update
`timescale 1ns / 1ps
package pdc_pkg;

    localparam int NUM_ZONES       = 16;
    localparam int FRAC_BITS       = 16;
    localparam int CELL_INDEX_BITS = 24;
    localparam int SLOTS_PER_ZONE  = 18;
    localparam int TENSOR_ELEMS    = 9;
    localparam int ZONE_W          = 4;
    localparam int SLOT_W          = 5;
    localparam int ZONE_AW         = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int SQ_STAGES       = 8;
    localparam int SQ_STEPS        = 4;
    localparam int MATH_STAGES     = 10;

    typedef logic signed [31:0] word_t;

    // one zone's coefficient tensors as read from the store
    typedef struct packed {
        word_t [TENSOR_ELEMS-1:0] alpha;
        word_t [TENSOR_ELEMS-1:0] beta;
    } coef_row_t;

    // per-cell values that travel with the item
    typedef struct packed {
        logic [CELL_INDEX_BITS-1:0] cell_index;
        logic [30:0]                vol;
        word_t [2:0]                u;
    } side_t;

    typedef struct packed {
        side_t     side;
        coef_row_t row;
    } cell_ctx_t;

    // pipeline advance and valid travel together
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    // saturate a wide signed value to the 32-bit range
    function automatic word_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ sv/pdc_coef_ram.sv @@
// coefficient store: one row of eighteen words per zone, word write, row read
`timescale 1ns / 1ps
module pdc_coef_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [pdc_pkg::ZONE_AW-1:0] wr_zone,
    input  logic [pdc_pkg::SLOT_W-1:0]  wr_slot,
    input  pdc_pkg::word_t            wr_data,
    input  logic                      rd_en,
    input  logic [pdc_pkg::ZONE_AW-1:0] rd_zone,
    output pdc_pkg::coef_row_t        rd_row
);

    logic [pdc_pkg::SLOTS_PER_ZONE-1:0][31:0] mem [pdc_pkg::NUM_ZONES];
    logic [pdc_pkg::SLOTS_PER_ZONE-1:0][31:0] row_reg;

    // word write into the zone's row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_zone][wr_slot] <= wr_data;
        end
    end

    // registered row read, one address per cycle while rd_en is high
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_reg <= mem[rd_zone];
        end
    end

    // split the row into alpha and beta
    always_comb begin
        for (int i = 0; i < pdc_pkg::TENSOR_ELEMS; i++) begin
            rd_row.alpha[i] = row_reg[i];
            rd_row.beta[i]  = row_reg[i + pdc_pkg::TENSOR_ELEMS];
        end
    end

endmodule

@@ sv/pdc_isqrt.sv @@
// pipelined integer square root, four result bits per stage
`timescale 1ns / 1ps
module pdc_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  pdc_pkg::pipe_ctl_t  ctl_in,
    input  logic [63:0]         x_in,
    input  pdc_pkg::cell_ctx_t  ctx_in,
    output logic                vld_out,
    output logic [31:0]         root_out,
    output pdc_pkg::cell_ctx_t  ctx_out
);

    localparam int LAST = pdc_pkg::SQ_STAGES - 1;

    logic               vld_reg  [pdc_pkg::SQ_STAGES];
    logic [63:0]        x_reg    [pdc_pkg::SQ_STAGES];
    logic [32:0]        rem_reg  [pdc_pkg::SQ_STAGES];
    logic [31:0]        root_reg [pdc_pkg::SQ_STAGES];
    pdc_pkg::cell_ctx_t ctx_reg  [pdc_pkg::SQ_STAGES];

    logic [63:0] x_next    [pdc_pkg::SQ_STAGES];
    logic [32:0] rem_next  [pdc_pkg::SQ_STAGES];
    logic [31:0] root_next [pdc_pkg::SQ_STAGES];

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
        logic [63:0] x;
        logic [32:0] rem;
        logic [31:0] root;
        logic [34:0] cur;
        logic [34:0] trial;
        for (int s = 0; s < pdc_pkg::SQ_STAGES; s++) begin
            if (s == 0) begin
                x    = x_in;
                rem  = '0;
                root = '0;
            end else begin
                x    = x_reg[s-1];
                rem  = rem_reg[s-1];
                root = root_reg[s-1];
            end
            for (int k = 0; k < pdc_pkg::SQ_STEPS; k++) begin
                cur   = {rem, x[63:62]};
                x     = {x[61:0], 2'b00};
                trial = {1'b0, root, 2'b01};
                if (cur >= trial) begin
                    cur  = cur - trial;
                    root = {root[30:0], 1'b1};
                end else begin
                    root = {root[30:0], 1'b0};
                end
                rem = cur[32:0];
            end
            x_next[s]    = x;
            rem_next[s]  = rem;
            root_next[s] = root;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < pdc_pkg::SQ_STAGES; s++) vld_reg[s] <= 1'b0;
        end else if (ctl_in.en) begin
            for (int s = 0; s < pdc_pkg::SQ_STAGES; s++) begin
                vld_reg[s] <= (s == 0) ? ctl_in.vld : vld_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // payload chain
    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            for (int s = 0; s < pdc_pkg::SQ_STAGES; s++) begin
                x_reg[s]    <= x_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                ctx_reg[s]  <= (s == 0) ? ctx_in : ctx_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign vld_out  = vld_reg[LAST];
    assign root_out = root_reg[LAST];
    assign ctx_out  = ctx_reg[LAST];

endmodule

@@ sv/pdc_drag_math.sv @@
// drag tensor, trace and volume scaling pipeline with output register
`timescale 1ns / 1ps
module pdc_drag_math (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pdc_pkg::pipe_ctl_t   ctl_in,
    input  logic [31:0]          mag,
    input  pdc_pkg::cell_ctx_t   ctx_in,
    input  logic [30:0]          density,
    output logic                 out_vld,
    output logic [pdc_pkg::CELL_INDEX_BITS-1:0] out_cell_index,
    output pdc_pkg::word_t       out_diag,
    output pdc_pkg::word_t       out_src_x,
    output pdc_pkg::word_t       out_src_y,
    output pdc_pkg::word_t       out_src_z
);

    localparam int F    = pdc_pkg::FRAC_BITS;
    localparam int NE   = pdc_pkg::TENSOR_ELEMS;
    localparam int LAST = pdc_pkg::MATH_STAGES - 1;

    logic           vld_reg  [pdc_pkg::MATH_STAGES];
    pdc_pkg::side_t side_reg [pdc_pkg::MATH_STAGES];

    logic signed [64:0] pb_reg [NE];
    pdc_pkg::word_t     al_reg [NE];
    pdc_pkg::word_t     s_reg  [NE];
    logic signed [63:0] pd_reg [NE];
    pdc_pkg::word_t     cd_reg [NE];
    pdc_pkg::word_t     cdt_reg [NE];
    pdc_pkg::word_t     tr5_reg;
    pdc_pkg::word_t     m_reg  [NE];
    pdc_pkg::word_t     tr6_reg;
    logic signed [63:0] pm_reg [NE];
    pdc_pkg::word_t     tr7_reg;
    pdc_pkg::word_t     w_reg  [3];
    pdc_pkg::word_t     tr8_reg;
    logic signed [63:0] pvd_reg;
    logic signed [63:0] pvw_reg [3];
    pdc_pkg::word_t     diag_reg;
    pdc_pkg::word_t     src_reg [3];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < pdc_pkg::MATH_STAGES; s++) vld_reg[s] <= 1'b0;
        end else if (ctl_in.en) begin
            for (int s = 0; s < pdc_pkg::MATH_STAGES; s++) begin
                vld_reg[s] <= (s == 0) ? ctl_in.vld : vld_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // arithmetic stages, one multiply or one add and saturate each
    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            for (int s = 0; s < pdc_pkg::MATH_STAGES; s++) begin
                side_reg[s] <= (s == 0) ? ctx_in.side : side_reg[(s == 0) ? 0 : s-1];
            end
            for (int i = 0; i < NE; i++) begin
                // beta times speed
                pb_reg[i] <= $signed(ctx_in.row.beta[i]) * $signed({1'b0, mag});
                al_reg[i] <= ctx_in.row.alpha[i];
                // alpha plus forchheimer part
                s_reg[i]  <= pdc_pkg::sat32(66'($signed(al_reg[i])) + 66'(pb_reg[i] >>> F));
                // scale by density
                pd_reg[i] <= $signed({1'b0, density}) * $signed(s_reg[i]);
                cd_reg[i] <= pdc_pkg::sat32(66'(pd_reg[i] >>> F));
                cdt_reg[i] <= cd_reg[i];
            end
            // trace
            tr5_reg <= pdc_pkg::sat32(66'($signed(cd_reg[0])) + 66'($signed(cd_reg[4]))
                                      + 66'($signed(cd_reg[8])));
            // remove trace from the diagonal
            for (int i = 0; i < NE; i++) begin
                if (i % 4 == 0) begin
                    m_reg[i] <= pdc_pkg::sat32(66'($signed(cdt_reg[i])) - 66'($signed(tr5_reg)));
                end else begin
                    m_reg[i] <= cdt_reg[i];
                end
            end
            tr6_reg <= tr5_reg;
            // tensor times velocity
            for (int i = 0; i < NE; i++) begin
                pm_reg[i] <= $signed(m_reg[i]) * $signed(side_reg[5].u[i % 3]);
            end
            tr7_reg <= tr6_reg;
            for (int r = 0; r < 3; r++) begin
                w_reg[r] <= pdc_pkg::sat32(66'(pm_reg[r*3] >>> F) + 66'(pm_reg[r*3+1] >>> F)
                                           + 66'(pm_reg[r*3+2] >>> F));
            end
            tr8_reg <= tr7_reg;
            // volume scaling
            pvd_reg <= $signed({1'b0, side_reg[7].vol}) * $signed(tr8_reg);
            for (int r = 0; r < 3; r++) begin
                pvw_reg[r] <= $signed({1'b0, side_reg[7].vol}) * $signed(w_reg[r]);
            end
            // output register
            diag_reg <= pdc_pkg::sat32(66'(pvd_reg >>> F));
            for (int r = 0; r < 3; r++) begin
                src_reg[r] <= pdc_pkg::sat32(66'(pvw_reg[r] >>> F));
            end
        end
    end

    assign out_vld        = vld_reg[LAST];
    assign out_cell_index = side_reg[LAST].cell_index;
    assign out_diag       = diag_reg;
    assign out_src_x      = src_reg[0];
    assign out_src_y      = src_reg[1];
    assign out_src_z      = src_reg[2];

endmodule

@@ sv/porous_drag_cell_update.sv @@
// porous drag cell update top level: input stage, coefficient store, root and drag pipelines
// throughput: one transaction per cycle while no result is stalled, set by the fully
// pipelined root and multiply lanes; load transactions with an in-range zone and slot
// write the coefficient store in the cycle of acceptance and give no result
// the whole pipeline advances together and holds while a result waits for m_ready
// reset clears all valid state and sets density to 1.0; the store is undefined until written
`timescale 1ns / 1ps
module porous_drag_cell_update (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [30:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [pdc_pkg::ZONE_W-1:0] s_zone,
    input  logic [pdc_pkg::SLOT_W-1:0] s_coeff_slot,
    input  logic signed [31:0]   s_coeff_value,
    input  logic [pdc_pkg::CELL_INDEX_BITS-1:0] s_cell_index,
    input  logic [30:0]          s_cell_volume,
    input  logic signed [31:0]   s_velocity_x,
    input  logic signed [31:0]   s_velocity_y,
    input  logic signed [31:0]   s_velocity_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [pdc_pkg::CELL_INDEX_BITS-1:0] m_cell_index_out,
    output logic signed [31:0]   m_diag_increment,
    output logic signed [31:0]   m_source_dec_x,
    output logic signed [31:0]   m_source_dec_y,
    output logic signed [31:0]   m_source_dec_z
);

    logic               en;
    logic               accept;
    logic               zone_ok;
    logic [30:0]        density_reg;
    logic               v1_reg;
    logic               ok1_reg;
    pdc_pkg::side_t     side1_reg;
    logic [63:0]        sq_reg [3];
    logic               v2_reg;
    logic [63:0]        sum2_reg;
    pdc_pkg::cell_ctx_t ctx2_reg;
    pdc_pkg::coef_row_t row;
    pdc_pkg::pipe_ctl_t sq_ctl;
    pdc_pkg::pipe_ctl_t math_ctl;
    logic               sq_vld;
    logic [31:0]        mag;
    pdc_pkg::cell_ctx_t sq_ctx;
    logic [31:0]        uabs [3];
    pdc_pkg::word_t     vin [3];

    // global advance
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign zone_ok   = 32'(s_zone) < pdc_pkg::NUM_ZONES;

    // density register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            density_reg <= 31'(1) << pdc_pkg::FRAC_BITS;
        end else if (cfg_valid && cfg_ready) begin
            density_reg <= cfg_data;
        end
    end

    pdc_coef_ram u_ram (
        .aclk    (aclk),
        .wr_en   (accept && !s_mode && zone_ok &&
                  (32'(s_coeff_slot) < pdc_pkg::SLOTS_PER_ZONE)),
        .wr_zone (s_zone[pdc_pkg::ZONE_AW-1:0]),
        .wr_slot (s_coeff_slot),
        .wr_data (s_coeff_value),
        .rd_en   (en),
        .rd_zone (s_zone[pdc_pkg::ZONE_AW-1:0]),
        .rd_row  (row)
    );

    // velocity magnitudes
    assign vin[0] = s_velocity_x;
    assign vin[1] = s_velocity_y;
    assign vin[2] = s_velocity_z;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            uabs[i] = vin[i][31] ? 32'(-vin[i]) : vin[i];
        end
    end

    // stage one: squares, side fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept && s_mode;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok1_reg              <= zone_ok;
            side1_reg.cell_index <= s_cell_index;
            side1_reg.vol        <= s_cell_volume;
            for (int i = 0; i < 3; i++) begin
                side1_reg.u[i] <= vin[i];
                sq_reg[i]      <= uabs[i] * uabs[i];
            end
            // stage two: sum of squares, coefficient row masked for an absent zone
            sum2_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            ctx2_reg.side <= side1_reg;
            ctx2_reg.row  <= ok1_reg ? row : '0;
        end
    end

    assign sq_ctl.en  = en;
    assign sq_ctl.vld = v2_reg;

    pdc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (sq_ctl),
        .x_in     (sum2_reg),
        .ctx_in   (ctx2_reg),
        .vld_out  (sq_vld),
        .root_out (mag),
        .ctx_out  (sq_ctx)
    );

    assign math_ctl.en  = en;
    assign math_ctl.vld = sq_vld;

    pdc_drag_math u_math (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl_in         (math_ctl),
        .mag            (mag),
        .ctx_in         (sq_ctx),
        .density        (density_reg),
        .out_vld        (m_valid),
        .out_cell_index (m_cell_index_out),
        .out_diag       (m_diag_increment),
        .out_src_x      (m_source_dec_x),
        .out_src_y      (m_source_dec_y),
        .out_src_z      (m_source_dec_z)
    );

endmodule

@@ sv/pdc_checker.sv @@
// port-level checks of the porous drag cell update and their binding
`timescale 1ns / 1ps
module pdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_cell_index_out,
    input logic [31:0] m_diag_increment
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_index_out)
                                && $stable(m_diag_increment))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is taken whenever the output stage is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    // no new transaction is taken while a result is stalled
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during stall");

endmodule

bind porous_drag_cell_update pdc_checker u_pdc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_cell_index_out (m_cell_index_out),
    .m_diag_increment (m_diag_increment)
);
